// ===== hw/rtl/tpcd_pkg.sv =====
// types and constants shared by the pattern command decoder
`timescale 1ns / 1ps
`default_nettype none

package tpcd_pkg;

  // command byte codes
  localparam logic [7:0] CMD_LAST_CHANNEL = 8'h03;
  localparam logic [7:0] CMD_ADVANCE      = 8'h04;
  localparam logic [7:0] CMD_JUMP         = 8'h05;
  localparam logic [7:0] CMD_END          = 8'h06;
  localparam logic [7:0] CMD_PAD          = 8'h66;

  // result kinds
  typedef enum logic [2:0] {
    KIND_CELL     = 3'd0,
    KIND_JUMP     = 3'd1,
    KIND_END      = 3'd2,
    KIND_UNKNOWN  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  // one input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_pattern;
  } in_t;

  // one result transaction
  typedef struct packed {
    kind_e      kind;
    logic [5:0] row;
    logic [1:0] channel;
    logic [6:0] note;
    logic [5:0] sample_number;
    logic [5:0] volume;
    logic [7:0] jump_position;
    logic [7:0] bad_byte;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tracker_pattern_command_decoder.sv =====
// Pattern command decoder: takes one pattern byte per transaction and returns
// at most one decoded event per byte. A byte is accepted in every cycle while
// in_ready_o is high; its result is registered before it is output. The
// result register is backed by a one-entry skid buffer, so input keeps
// flowing while the output waits, and in_ready_o drops only when both are
// full. The decoder holds its state in a few flip-flops and needs no clearing
// pass after reset. ROWS sets the number of rows in a pattern (2 to 256); the
// row field carries the low six bits of the row index.
`timescale 1ns / 1ps
`default_nettype none

module tracker_pattern_command_decoder #(
  parameter int ROWS = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire tpcd_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output tpcd_pkg::out_t       out_data_o
);
  import tpcd_pkg::*;

  logic in_accept;
  logic out_take;
  logic res_valid;
  out_t res;

  logic out_valid_q;
  out_t out_q;
  logic skid_valid_q;
  out_t skid_q;

  assign in_ready_o  = !skid_valid_q;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_take    = out_valid_q && out_ready_i;

  // decode each accepted byte
  tpcd_parser #(
    .ROWS(ROWS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_accept),
    .item_i     (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register and skid buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept && res_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpcd_parser.sv =====
// command parser: decoder state and the result of each accepted byte
`timescale 1ns / 1ps
`default_nettype none

module tpcd_parser #(
  parameter int ROWS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire tpcd_pkg::in_t  item_i,
  output logic              res_valid_o,
  output tpcd_pkg::out_t    res_o
);
  import tpcd_pkg::*;

  localparam int RowW = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int SumW = ((RowW > 8) ? RowW : 8) + 1;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_CELL1 = 3'd1,
    PH_CELL2 = 3'd2,
    PH_ADV   = 3'd3,
    PH_JUMP  = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d, phase_eff;
  logic [RowW-1:0]   row_q, row_d, row_eff;
  logic [1:0]        chan_q, chan_d;
  logic [7:0]        first_q, first_d;
  logic              stopped_q, stopped_d, stopped_eff;
  logic [SumW-1:0]   row_wide;
  logic [SumW-1:0]   row_sum;
  logic [7:0]        b;

  assign b        = item_i.data_byte;
  assign row_wide = SumW'(row_eff);
  assign row_sum  = row_wide + SumW'(b);

  // new pattern clears row, phase and stop before decoding
  always_comb begin
    phase_eff   = item_i.new_pattern ? PH_CMD : phase_q;
    row_eff     = item_i.new_pattern ? '0 : row_q;
    stopped_eff = item_i.new_pattern ? 1'b0 : stopped_q;
  end

  // next state and result for the current byte
  always_comb begin
    phase_d     = phase_eff;
    row_d       = row_eff;
    chan_d      = chan_q;
    first_d     = first_q;
    stopped_d   = stopped_eff;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.row   = row_wide[5:0];
    if (!stopped_eff) begin
      unique case (phase_eff)
        PH_CELL1: begin
          first_d = b;
          phase_d = PH_CELL2;
        end
        PH_CELL2: begin
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_CELL;
          res_o.channel       = chan_q;
          res_o.note          = b[6:0];
          res_o.sample_number = {1'b0, b[7], first_q[7:4]} + 6'd1;
          res_o.volume        = {first_q[3:0], 2'b00};
          phase_d             = PH_CMD;
        end
        PH_ADV: begin
          phase_d = PH_CMD;
          if (row_sum >= SumW'(ROWS)) begin
            stopped_d   = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_OVERFLOW;
          end else begin
            row_d = row_sum[RowW-1:0];
          end
        end
        PH_JUMP: begin
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_JUMP;
          res_o.jump_position = b;
          phase_d             = PH_CMD;
        end
        PH_CMD: begin
          phase_d = PH_CMD;
          if (b == CMD_PAD) begin
            phase_d = PH_CMD;
          end else if (b <= CMD_LAST_CHANNEL) begin
            chan_d  = b[1:0];
            phase_d = PH_CELL1;
          end else if (b == CMD_ADVANCE) begin
            phase_d = PH_ADV;
          end else if (b == CMD_JUMP) begin
            phase_d = PH_JUMP;
          end else if (b == CMD_END) begin
            stopped_d   = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_END;
          end else begin
            res_valid_o    = 1'b1;
            res_o.kind     = KIND_UNKNOWN;
            res_o.bad_byte = b;
          end
        end
        default: begin
          phase_d = PH_CMD;
        end
      endcase
    end
  end

  // parser state, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CMD;
      row_q     <= '0;
      chan_q    <= '0;
      first_q   <= '0;
      stopped_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      row_q     <= row_d;
      chan_q    <= chan_d;
      first_q   <= first_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpcd_checker.sv =====
// port-level checks for the pattern command decoder and their binding
`timescale 1ns / 1ps
`default_nettype none

module tpcd_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_ready_o,
  input  wire logic           out_valid_o,
  input  wire logic           out_ready_i,
  input  wire tpcd_pkg::out_t out_data_o
);
  import tpcd_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // cell events carry a sample in range and a volume in steps of four
  a_cell_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_CELL |->
      out_data_o.sample_number != 6'd0 && out_data_o.sample_number <= 6'd32 &&
      out_data_o.volume[1:0] == 2'b00)
    else $error("cell event fields out of range");

  // non-cell results leave the cell fields clear
  a_cell_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_CELL |->
      out_data_o.channel == 2'd0 && out_data_o.note == 7'd0 &&
      out_data_o.sample_number == 6'd0 && out_data_o.volume == 6'd0)
    else $error("cell fields set on non-cell result");

  // an unknown command is never a known code
  a_unknown_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_UNKNOWN |->
      out_data_o.bad_byte > CMD_END && out_data_o.bad_byte != CMD_PAD)
    else $error("known command reported as unknown");

endmodule

bind tracker_pattern_command_decoder tpcd_checker u_tpcd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the tracker pattern command decoder
`timescale 1ns / 1ps

module testbench;
  import tpcd_pkg::*;

  localparam int ROWS         = 64;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;

  // parser phases of the decoder model
  typedef enum logic [2:0] {
    WAIT_CMD,
    CELL_FIRST,
    CELL_SECOND,
    ADV_STEP,
    JUMP_POS
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // byte stream waiting to be driven and decoded events still owed
  in_t  pattern_bytes[$];
  out_t expected_events[$];

  // decoder model state
  parse_phase_e parse_phase;
  logic [7:0]   row_pos;
  logic [1:0]   cell_channel;
  logic [7:0]   cell_first;
  logic         halted;

  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;

  tracker_pattern_command_decoder #(
    .ROWS(ROWS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // clock
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // decode one byte; returns 1 when the byte completes a reported event
  function automatic bit decode_byte(input in_t item, output out_t ev);
    logic [7:0] b;
    b = item.data_byte;
    ev = '0;
    ev.row = row_pos[5:0];
    if (item.new_pattern) begin
      parse_phase = WAIT_CMD;
      row_pos = '0;
      halted = 1'b0;
      ev.row = '0;
    end
    if (halted) return 1'b0;
    case (parse_phase)
      CELL_FIRST: begin
        cell_first = b;
        parse_phase = CELL_SECOND;
        return 1'b0;
      end
      CELL_SECOND: begin
        ev.kind = KIND_CELL;
        ev.channel = cell_channel;
        ev.note = b[6:0];
        ev.sample_number = {1'b0, b[7], cell_first[7:4]} + 6'd1;
        ev.volume = {cell_first[3:0], 2'b00};
        parse_phase = WAIT_CMD;
        return 1'b1;
      end
      ADV_STEP: begin
        parse_phase = WAIT_CMD;
        if (int'(row_pos) + int'(b) >= ROWS) begin
          halted = 1'b1;
          ev.kind = KIND_OVERFLOW;
          return 1'b1;
        end
        row_pos = row_pos + b;
        return 1'b0;
      end
      JUMP_POS: begin
        ev.kind = KIND_JUMP;
        ev.jump_position = b;
        parse_phase = WAIT_CMD;
        return 1'b1;
      end
      default: ;
    endcase
    // command byte
    parse_phase = WAIT_CMD;
    if (b == CMD_PAD) return 1'b0;
    if (b <= CMD_LAST_CHANNEL) begin
      cell_channel = b[1:0];
      parse_phase = CELL_FIRST;
      return 1'b0;
    end
    if (b == CMD_ADVANCE) begin
      parse_phase = ADV_STEP;
      return 1'b0;
    end
    if (b == CMD_JUMP) begin
      parse_phase = JUMP_POS;
      return 1'b0;
    end
    if (b == CMD_END) begin
      halted = 1'b1;
      ev.kind = KIND_END;
      return 1'b1;
    end
    ev.kind = KIND_UNKNOWN;
    ev.bad_byte = b;
    return 1'b1;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic np);
    in_t item;
    item.data_byte = b;
    item.new_pattern = np;
    pattern_bytes.push_back(item);
  endtask

  // one random pattern, mostly well-formed commands with random operands
  task automatic add_pattern();
    int n_cmds;
    int pick;
    logic np;
    logic [7:0] b;
    n_cmds = $urandom_range(4, 40);
    for (int k = 0; k < n_cmds; k++) begin
      np = (k == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_byte(8'($urandom_range(0, 3)), np);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b0);
      end else if (pick < 60) begin
        push_byte(CMD_ADVANCE, np);
        if ($urandom_range(0, 9) == 0) b = 8'($urandom);
        else b = 8'($urandom_range(0, 5));
        push_byte(b, 1'b0);
      end else if (pick < 68) begin
        push_byte(CMD_JUMP, np);
        push_byte(8'($urandom), 1'b0);
      end else if (pick < 75) begin
        push_byte(CMD_PAD, np);
      end else if (pick < 80) begin
        // unrecognized command byte
        do b = 8'($urandom_range(7, 255)); while (b == CMD_PAD);
        push_byte(b, np);
      end else if (pick < 86) begin
        push_byte(8'($urandom), np | ($urandom_range(0, 9) == 0));
      end else if (pick < 92) begin
        // new pattern cuts into a cell event
        push_byte(8'($urandom_range(0, 3)), np);
        push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom_range(0, 6)), 1'b1);
      end else if (pick < 95) begin
        push_byte(CMD_END, np);
      end else begin
        push_byte(CMD_ADVANCE, np);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if ($urandom_range(0, 9) < 7) push_byte(CMD_END, 1'b0);
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
  endtask

  // stimulus, reset and end of run
  initial begin
    parse_phase = WAIT_CMD;
    row_pos = '0;
    cell_channel = '0;
    cell_first = '0;
    halted = 1'b0;

    // directed: padding, cell extremes, jumps, unknown bytes
    push_byte(CMD_PAD, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'h5a, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(CMD_JUMP, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(CMD_JUMP, 1'b0); push_byte(8'hff, 1'b0);
    push_byte(8'h07, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'h65, 1'b0);
    // advance by zero, then to the last row, then end there
    push_byte(CMD_ADVANCE, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(CMD_ADVANCE, 1'b0); push_byte(8'd63, 1'b0);
    push_byte(CMD_END, 1'b0);
    // stopped: bytes are ignored
    push_byte(8'h00, 1'b0); push_byte(8'h07, 1'b0);
    // new pattern, advance that overflows the row count
    push_byte(CMD_ADVANCE, 1'b1); push_byte(8'd64, 1'b0);
    push_byte(CMD_PAD, 1'b0);
    // new pattern in the middle of a cell event
    push_byte(8'h02, 1'b1); push_byte(8'h11, 1'b0);
    push_byte(CMD_JUMP, 1'b1); push_byte(8'h22, 1'b0);
    push_byte(CMD_END, 1'b1);

    while (pattern_bytes.size() < RANDOM_ITEMS) add_pattern();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;

    // wait until the stream is consumed and every event has come out
    @(posedge clk_i);
    while (pattern_bytes.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // driver: bursts of transactions separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_n) begin
    out_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, ev)) expected_events.push_back(ev);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pattern_bytes.size() > 0) begin
          in_data <= pattern_bytes.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            case ($urandom_range(0, 4))
              0: burst_left = $urandom_range(100, 300);
              1: burst_left = 1;
              default: burst_left = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 2);
              default: gap_left = $urandom_range(3, 12);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string field, input int unsigned exp_v,
                              input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    error_count++;
  endtask

  // compare one result transaction with the oldest expected event
  task automatic check_event(input out_t got);
    out_t exp_ev;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected result, expected none, got kind %0d row %0d",
               $time, got.kind, got.row);
      error_count++;
    end else begin
      exp_ev = expected_events.pop_front();
      if (got.kind !== exp_ev.kind) report_field("kind", exp_ev.kind, got.kind);
      if (got.row !== exp_ev.row) report_field("row", exp_ev.row, got.row);
      if (got.channel !== exp_ev.channel)
        report_field("channel", exp_ev.channel, got.channel);
      if (got.note !== exp_ev.note) report_field("note", exp_ev.note, got.note);
      if (got.sample_number !== exp_ev.sample_number)
        report_field("sample_number", exp_ev.sample_number, got.sample_number);
      if (got.volume !== exp_ev.volume)
        report_field("volume", exp_ev.volume, got.volume);
      if (got.jump_position !== exp_ev.jump_position)
        report_field("jump_position", exp_ev.jump_position, got.jump_position);
      if (got.bad_byte !== exp_ev.bad_byte)
        report_field("bad_byte", exp_ev.bad_byte, got.bad_byte);
    end
  endtask

  // monitor: checks results and stalls the output on its own pattern
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int phase_tick = 0;

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_event(out_data);
        results_seen++;
      end
      // one long hold-off so the input side backs up
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      phase_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= phase_tick[0];
        endcase
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hw/rtl/tpcd_pkg.sv
hw/rtl/tpcd_parser.sv
hw/rtl/tracker_pattern_command_decoder.sv
hw/rtl/tpcd_checker.sv
test/testbench.sv
